// ===== rtl/kss_pkg.sv =====
// shared types and constants of the keyed session slot table
// no dependencies
package kss_pkg;

    localparam int KEY_W    = 31;
    localparam int HANDLE_W = 16;
    localparam int IP_W     = 32;
    localparam int PORT_W   = 16;
    localparam int INDEX_W  = 7;

    typedef enum logic [1:0] {
        ACT_FILL_CONN = 2'd0,
        ACT_TAKE_CONN = 2'd1,
        ACT_FILL_ADDR = 2'd2,
        ACT_TAKE_ADDR = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] conn_handle;
        logic [IP_W-1:0]     peer_ip;
        logic [PORT_W-1:0]   peer_port;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [INDEX_W-1:0]  slot_index;
        logic [HANDLE_W-1:0] out_handle;
        logic                evicted_valid;
        logic [HANDLE_W-1:0] evicted_handle;
        logic [IP_W-1:0]     out_ip;
        logic [PORT_W-1:0]   out_port;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [IP_W-1:0]     ip;
        logic [PORT_W-1:0]   port;
    } entry_t;

endpackage

// ===== rtl/kss_stream_if.sv =====
// valid/ready stream interface carrying one payload beat
// payload type is set by the instantiating side, usually from kss_pkg
interface kss_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/kss_slot_ram.sv =====
// slot entry memory: one write port, one registered read port
// depends on kss_pkg for the entry type
module kss_slot_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  kss_pkg::entry_t   wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output kss_pkg::entry_t   rd_data
);

    kss_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/keyed_session_slot_table.sv =====
// keyed session slot table top level: sequencer, scan compare and response register
// depends on kss_pkg, kss_stream_if and kss_slot_ram
//
// channel  dir  payload          beat
// req      in   kss_pkg::req_t   one request
// rsp      out  kss_pkg::rsp_t   one result per request
//
// each request scans every slot through the single memory read port, one slot a cycle,
// then reads the chosen slot and, for the actions that change it, writes it back
// after reset a clearing pass writes every slot to zero, with req.ready low
// req.ready is high only while the sequencer is idle
// a finished result waits in the output register; the next request may scan meanwhile
// and its write-back waits until that result is taken
module keyed_session_slot_table #(
    parameter int SLOT_COUNT = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    kss_stream_if.sink   req,
    kss_stream_if.source rsp
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_LOOK
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               issue_reg, issue_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               match_hit_reg, match_hit_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic               empty_hit_reg, empty_hit_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    kss_pkg::req_t      req_reg, req_next;
    logic               rsp_valid_reg, rsp_valid_next;
    kss_pkg::rsp_t      rsp_reg, rsp_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    kss_pkg::entry_t    wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    kss_pkg::entry_t    rd_data;

    logic               rsp_free;
    logic               key_eq;
    logic               key_zero;
    kss_pkg::entry_t    upd;
    kss_pkg::rsp_t      res;
    logic               upd_wr;

    kss_slot_ram #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    assign key_eq   = (rd_data.key == req_reg.key);
    assign key_zero = (rd_data.key == '0);

    // result and write-back of the slot that was read in the pick step
    always_comb
    begin
        res    = '0;
        upd    = rd_data;
        upd_wr = 1'b0;
        if (req_reg.key != '0)
        begin
            case (req_reg.action)
                kss_pkg::ACT_FILL_CONN:
                begin
                    res.found      = 1'b1;
                    res.slot_index = kss_pkg::INDEX_W'(slot_reg);
                    if (rd_data.handle != '0)
                    begin
                        res.evicted_valid  = 1'b1;
                        res.evicted_handle = rd_data.handle;
                    end
                    upd.handle = req_reg.conn_handle;
                    upd.key    = req_reg.key;
                    upd_wr     = 1'b1;
                end
                kss_pkg::ACT_TAKE_CONN:
                begin
                    if (match_hit_reg)
                    begin
                        res.found      = 1'b1;
                        res.slot_index = kss_pkg::INDEX_W'(slot_reg);
                        res.out_handle = rd_data.handle;
                        upd.handle     = '0;
                        upd_wr         = 1'b1;
                    end
                end
                kss_pkg::ACT_FILL_ADDR:
                begin
                    res.found      = 1'b1;
                    res.slot_index = kss_pkg::INDEX_W'(slot_reg);
                    upd.ip         = req_reg.peer_ip;
                    upd.port       = req_reg.peer_port;
                    upd.key        = req_reg.key;
                    upd_wr         = 1'b1;
                end
                kss_pkg::ACT_TAKE_ADDR:
                begin
                    if (match_hit_reg)
                    begin
                        res.found      = 1'b1;
                        res.slot_index = kss_pkg::INDEX_W'(slot_reg);
                        res.out_ip     = rd_data.ip;
                        res.out_port   = rd_data.port;
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        match_hit_next = match_hit_reg;
        match_idx_next = match_idx_reg;
        empty_hit_next = empty_hit_reg;
        empty_idx_next = empty_idx_reg;
        slot_next      = slot_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_next       = req.data;
                    cnt_next       = '0;
                    issue_next     = 1'b1;
                    match_hit_next = 1'b0;
                    empty_hit_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = cnt_reg;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = cnt_reg;
                    if (cnt_reg == LAST)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (cmp_valid_reg)
                begin
                    // first match and first empty slot in table order
                    if (key_eq && !match_hit_reg)
                    begin
                        match_hit_next = 1'b1;
                        match_idx_next = cmp_idx_reg;
                    end
                    if (key_zero && !empty_hit_reg)
                    begin
                        empty_hit_next = 1'b1;
                        empty_idx_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST)
                    begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK:
            begin
                if (match_hit_reg)
                begin
                    slot_next = match_idx_reg;
                end
                else if (empty_hit_reg)
                begin
                    slot_next = empty_idx_reg;
                end
                else
                begin
                    slot_next = '0;
                end
                rd_en      = 1'b1;
                rd_addr    = slot_next;
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (rsp_free)
                begin
                    wr_en          = upd_wr;
                    wr_addr        = slot_reg;
                    wr_data        = upd;
                    rsp_valid_next = 1'b1;
                    rsp_next       = res;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            match_hit_reg <= 1'b0;
            match_idx_reg <= '0;
            empty_hit_reg <= 1'b0;
            empty_idx_reg <= '0;
            slot_reg      <= '0;
            req_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            match_hit_reg <= match_hit_next;
            match_idx_reg <= match_idx_next;
            empty_hit_reg <= empty_hit_next;
            empty_idx_reg <= empty_idx_next;
            slot_reg      <= slot_next;
            req_reg       <= req_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    a_clear_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request taken during clearing pass");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_LOOK))
        else $error("slot memory written outside clear or write-back");

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_SCAN && issue_reg))
        else $error("accepted request did not start a scan");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.data.found) |->
            (rsp.data.out_handle == '0 && !rsp.data.evicted_valid &&
             rsp.data.out_ip == '0 && rsp.data.out_port == '0 &&
             rsp.data.slot_index == '0))
        else $error("miss result carries nonzero fields");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK && rsp.valid && !rsp.ready) |=> (state_reg == ST_LOOK))
        else $error("write-back overtook a waiting result");

endmodule

// ===== tb/tb_keyed_session_slot_table.sv =====
// self-checking testbench of the keyed session slot table: directed requests, then random ones
// with idling on both sides and one long result stall; results are checked against a slot model
// depends on kss_pkg, kss_stream_if and keyed_session_slot_table
module tb_keyed_session_slot_table;

    localparam int SLOTS       = 128;
    localparam int RANDOM_REQS = 750;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_WAIT  = SLOTS + 40;

    logic clk = 1'b0;
    logic rst_n;

    kss_stream_if #(.payload_t(kss_pkg::req_t)) req_if ();
    kss_stream_if #(.payload_t(kss_pkg::rsp_t)) rsp_if ();

    keyed_session_slot_table #(.SLOT_COUNT(SLOTS)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [kss_pkg::KEY_W-1:0]    slot_keys    [SLOTS];
    logic [kss_pkg::HANDLE_W-1:0] slot_handles [SLOTS];
    logic [kss_pkg::IP_W-1:0]     slot_ips     [SLOTS];
    logic [kss_pkg::PORT_W-1:0]   slot_ports   [SLOTS];

    kss_pkg::req_t             queued_reqs [$];
    kss_pkg::rsp_t             awaited_rsps [$];
    logic [kss_pkg::KEY_W-1:0] known_keys [$];

    int total_items = 0;
    int sent_count  = 0;
    int taken_count = 0;
    int mismatches  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int match_slot(logic [kss_pkg::KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_keys[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int target_slot(logic [kss_pkg::KEY_W-1:0] key);
        int s;
        s = match_slot(key);
        if (s >= 0)
            return s;
        for (int i = 0; i < SLOTS; i++)
            if (slot_keys[i] == '0)
                return i;
        return 0;
    endfunction

    task automatic predict_request(input kss_pkg::req_t r);
        kss_pkg::rsp_t res;
        int            s;
        res = '0;
        if (r.key != '0)
        begin
            case (r.action)
                kss_pkg::ACT_FILL_CONN:
                begin
                    s = target_slot(r.key);
                    if (slot_handles[s] != '0)
                    begin
                        res.evicted_valid  = 1'b1;
                        res.evicted_handle = slot_handles[s];
                    end
                    slot_handles[s] = r.conn_handle;
                    slot_keys[s]    = r.key;
                    res.found       = 1'b1;
                    res.slot_index  = s[kss_pkg::INDEX_W-1:0];
                end
                kss_pkg::ACT_TAKE_CONN:
                begin
                    s = match_slot(r.key);
                    if (s >= 0)
                    begin
                        res.found       = 1'b1;
                        res.slot_index  = s[kss_pkg::INDEX_W-1:0];
                        res.out_handle  = slot_handles[s];
                        slot_handles[s] = '0;
                    end
                end
                kss_pkg::ACT_FILL_ADDR:
                begin
                    s = target_slot(r.key);
                    slot_ips[s]    = r.peer_ip;
                    slot_ports[s]  = r.peer_port;
                    slot_keys[s]   = r.key;
                    res.found      = 1'b1;
                    res.slot_index = s[kss_pkg::INDEX_W-1:0];
                end
                default:
                begin
                    s = match_slot(r.key);
                    if (s >= 0)
                    begin
                        res.found      = 1'b1;
                        res.slot_index = s[kss_pkg::INDEX_W-1:0];
                        res.out_ip     = slot_ips[s];
                        res.out_port   = slot_ports[s];
                    end
                end
            endcase
        end
        awaited_rsps.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    function automatic int idle_pct(int count, bit receiver);
        if (count < total_items / 3)
            return receiver ? 69 : 33;
        if (count < 2 * total_items / 3)
            return receiver ? 33 : 69;
        return 0;
    endfunction

    task automatic add_req(input kss_pkg::action_t act,
                           input logic [kss_pkg::KEY_W-1:0] key,
                           input logic [kss_pkg::HANDLE_W-1:0] handle,
                           input logic [kss_pkg::IP_W-1:0] ip,
                           input logic [kss_pkg::PORT_W-1:0] port);
        kss_pkg::req_t r;
        r.action      = act;
        r.key         = key;
        r.conn_handle = handle;
        r.peer_ip     = ip;
        r.peer_port   = port;
        queued_reqs.push_back(r);
    endtask

    // mostly keys already in use, recent ones preferred; fresh keys are mostly filled to grow the table
    task automatic add_random_req();
        kss_pkg::req_t r;
        int            pick;
        int            back;
        r.action      = kss_pkg::action_t'($urandom_range(3));
        r.conn_handle = ($urandom_range(9) == 0) ? '0 : kss_pkg::HANDLE_W'($urandom);
        r.peer_ip     = $urandom;
        r.peer_port   = kss_pkg::PORT_W'($urandom);
        pick          = $urandom_range(99);
        if (pick < 3)
            r.key = '0;
        else if (pick < 28 || known_keys.size() == 0)
        begin
            r.key = kss_pkg::KEY_W'($urandom_range(32'h7fff_ffff, 1));
            known_keys.push_back(r.key);
            if ($urandom_range(4) != 0)
                r.action = $urandom_range(1) ? kss_pkg::ACT_FILL_CONN : kss_pkg::ACT_FILL_ADDR;
        end
        else if (pick < 64)
        begin
            back  = $urandom_range((known_keys.size() > 8) ? 7 : known_keys.size() - 1);
            r.key = known_keys[known_keys.size() - 1 - back];
        end
        else
            r.key = known_keys[$urandom_range(known_keys.size() - 1)];
        queued_reqs.push_back(r);
    endtask

    initial
    begin
        rst_n = 1'b0;
        foreach (slot_keys[i])
        begin
            slot_keys[i]    = '0;
            slot_handles[i] = '0;
            slot_ips[i]     = '0;
            slot_ports[i]   = '0;
        end

        // misses on an empty table, then zero keys
        add_req(kss_pkg::ACT_TAKE_CONN, 31'h0000_1234, 16'hffff, 32'hffff_ffff, 16'hffff);
        add_req(kss_pkg::ACT_TAKE_ADDR, 31'h0000_1234, 16'hffff, 32'hffff_ffff, 16'hffff);
        add_req(kss_pkg::ACT_FILL_CONN, '0, 16'hffff, 32'hffff_ffff, 16'hffff);
        add_req(kss_pkg::ACT_FILL_ADDR, '0, 16'hffff, 32'hffff_ffff, 16'hffff);
        add_req(kss_pkg::ACT_TAKE_CONN, '0, 16'hffff, 32'hffff_ffff, 16'hffff);
        add_req(kss_pkg::ACT_TAKE_ADDR, '0, 16'hffff, 32'hffff_ffff, 16'hffff);
        // eviction, take, and take of a handle that is not ready
        add_req(kss_pkg::ACT_FILL_CONN, 31'h0000_1234, 16'hffff, '0, '0);
        add_req(kss_pkg::ACT_FILL_CONN, 31'h0000_1234, 16'h1234, '0, '0);
        add_req(kss_pkg::ACT_TAKE_CONN, 31'h0000_1234, '0, '0, '0);
        add_req(kss_pkg::ACT_TAKE_CONN, 31'h0000_1234, '0, '0, '0);
        add_req(kss_pkg::ACT_FILL_CONN, 31'h0000_1234, '0, '0, '0);
        // address extremes on the largest key, then requests across several keys
        add_req(kss_pkg::ACT_FILL_ADDR, 31'h7fff_ffff, 16'hffff, 32'hffff_ffff, 16'hffff);
        add_req(kss_pkg::ACT_TAKE_ADDR, 31'h7fff_ffff, '0, '0, '0);
        add_req(kss_pkg::ACT_FILL_ADDR, 31'h7fff_ffff, '0, '0, '0);
        add_req(kss_pkg::ACT_TAKE_ADDR, 31'h7fff_ffff, 16'hffff, 32'hffff_ffff, 16'hffff);
        add_req(kss_pkg::ACT_FILL_ADDR, 31'h0000_1234, '0, 32'h8000_0001, 16'h8001);
        add_req(kss_pkg::ACT_TAKE_ADDR, 31'h0000_1234, '0, '0, '0);
        add_req(kss_pkg::ACT_FILL_CONN, 31'h7fff_ffff, 16'h0001, '0, '0);
        add_req(kss_pkg::ACT_TAKE_CONN, 31'h0000_0001, '0, '0, '0);
        add_req(kss_pkg::ACT_FILL_CONN, 31'h0000_0001, 16'h8000, 32'h5555_aaaa, 16'h55aa);
        add_req(kss_pkg::ACT_TAKE_ADDR, 31'h0000_0001, '0, '0, '0);
        add_req(kss_pkg::ACT_TAKE_CONN, 31'h7fff_ffff, '0, '0, '0);
        known_keys.push_back(31'h0000_1234);
        known_keys.push_back(31'h7fff_ffff);
        known_keys.push_back(31'h0000_0001);

        repeat (RANDOM_REQS)
            add_random_req();
        total_items = queued_reqs.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_reqs.size() != 0 || req_if.valid || awaited_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && awaited_rsps.size() == 0)
            $display("PASS keyed_session_slot_table");
        else
            $display("FAIL keyed_session_slot_table");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("FAIL keyed_session_slot_table");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                predict_request(req_if.data);
                sent_count++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (queued_reqs.size() != 0 && $urandom_range(99) >= idle_pct(sent_count, 1'b0))
                begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= queued_reqs.pop_front();
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        kss_pkg::rsp_t want;
        kss_pkg::rsp_t got;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.data;
                taken_count++;
                if (awaited_rsps.size() == 0)
                begin
                    $error("result beat with no request waiting: %p", got);
                    mismatches++;
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("slot_index", want.slot_index, got.slot_index);
                    check_field("out_handle", want.out_handle, got.out_handle);
                    check_field("evicted_valid", want.evicted_valid, got.evicted_valid);
                    check_field("evicted_handle", want.evicted_handle, got.evicted_handle);
                    check_field("out_ip", want.out_ip, got.out_ip);
                    check_field("out_port", want.out_port, got.out_port);
                end
            end
            // long stall late in the run so the request side backs up
            if (!hold_done && taken_count >= 2 * total_items / 3 + 40)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= idle_pct(taken_count, 1'b1));
        end
    end

endmodule
